>>> src/ppv_pkg.sv
`default_nettype none
package ppv_pkg;

  // field widths
  localparam int unsigned PT_W    = 24;
  localparam int unsigned ROT_W   = 18;
  localparam int unsigned ROW_W   = 3 * ROT_W;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned PAD_W   = 6;
  localparam int unsigned PDATA_W = 64;

  // internal datapath widths
  localparam int unsigned PRD_W   = ROT_W + PT_W;   // one rotation product
  localparam int unsigned C28_W   = 44;             // camera coordinate, Q.28
  localparam int unsigned FRAC_SH = 12;             // Q.28 -> Q.16
  localparam int unsigned D_W     = C28_W - FRAC_SH;
  localparam int unsigned P_W     = D_W + SCALE_W;  // xc * fx
  localparam int unsigned Q_W     = 47;             // quotient bits kept
  localparam int unsigned HI_SH   = Q_W - FRAC_SH;  // numerator bits above quotient
  localparam int unsigned PIX_W   = 47;             // clamped pixel, Q.16

  // camera depth 0.001 in Q.28, rounded up
  localparam logic signed [C28_W-1:0] DEPTH_MIN_Q28 = C28_W'(268436);

  // register reset values
  localparam logic [ROW_W-1:0] ROT_X_RST = ROW_W'(65536);
  localparam logic [ROW_W-1:0] ROT_Y_RST = ROW_W'(65536) << ROT_W;
  localparam logic [ROW_W-1:0] ROT_Z_RST = ROW_W'(65536) << (2 * ROT_W);
  localparam logic [23:0]      IMG_RST   = 24'd1966720;

  typedef enum logic [2:0] {
    REG_ROT_X   = 3'd0,
    REG_ROT_Y   = 3'd1,
    REG_ROT_Z   = 3'd2,
    REG_TRANS_XY = 3'd3,
    REG_TRANS_Z = 3'd4,
    REG_INTRIN  = 3'd5,
    REG_IMG     = 3'd6,
    REG_FOV     = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_BEHIND  = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_VISIBLE = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [PT_W-1:0] pt_x;
    logic signed [PT_W-1:0] pt_y;
    logic signed [PT_W-1:0] pt_z;
    logic [SCALE_W-1:0]     scale;
  } pt_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] u_pos;
    logic signed [POS_W-1:0] v_pos;
    logic [1:0]              status;
  } pt_out_t;

  typedef struct packed {
    logic [ROW_W-1:0] rot_x;
    logic [ROW_W-1:0] rot_y;
    logic [ROW_W-1:0] rot_z;
    logic [47:0]      trans_xy;
    logic [23:0]      trans_z;
    logic [63:0]      intrinsics;
    logic [23:0]      image_size;
    logic [14:0]      fov_margin;
  } cfg_t;

  // camera-frame result handed to the divider
  typedef struct packed {
    logic signed [P_W-1:0] num_u;
    logic signed [P_W-1:0] num_v;
    logic [D_W-1:0]        den;
    logic [SCALE_W-1:0]    scale;
    logic                  behind;
  } proj_t;

  typedef struct packed {
    logic [D_W-1:0] rem;
    logic [Q_W-1:0] num_lo;
    logic [Q_W-1:0] quo;
    logic           neg;
    logic           ovf;
  } div_lane_t;

  typedef struct packed {
    div_lane_t          u;
    div_lane_t          v;
    logic [D_W-1:0]     den;
    logic [SCALE_W-1:0] scale;
    logic               behind;
  } div_t;

endpackage
`default_nettype wire

>>> src/ppv_cfg_regs.sv
`default_nettype none
module ppv_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ppv_pkg::PAD_W-1:0]    paddr,
  input  wire logic [ppv_pkg::PDATA_W-1:0]  pwdata,
  output logic      [ppv_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  output ppv_pkg::cfg_t                     cfg_o
);

  ppv_pkg::cfg_t     cfg_q;
  ppv_pkg::reg_idx_e idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = ppv_pkg::reg_idx_e'(paddr[5:3]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot_x      <= ppv_pkg::ROT_X_RST;
      cfg_q.rot_y      <= ppv_pkg::ROT_Y_RST;
      cfg_q.rot_z      <= ppv_pkg::ROT_Z_RST;
      cfg_q.trans_xy   <= '0;
      cfg_q.trans_z    <= '0;
      cfg_q.intrinsics <= '0;
      cfg_q.image_size <= ppv_pkg::IMG_RST;
      cfg_q.fov_margin <= '0;
    end else if (wr_en) begin
      unique case (idx)
        ppv_pkg::REG_ROT_X:    cfg_q.rot_x      <= pwdata[ppv_pkg::ROW_W-1:0];
        ppv_pkg::REG_ROT_Y:    cfg_q.rot_y      <= pwdata[ppv_pkg::ROW_W-1:0];
        ppv_pkg::REG_ROT_Z:    cfg_q.rot_z      <= pwdata[ppv_pkg::ROW_W-1:0];
        ppv_pkg::REG_TRANS_XY: cfg_q.trans_xy   <= pwdata[47:0];
        ppv_pkg::REG_TRANS_Z:  cfg_q.trans_z    <= pwdata[23:0];
        ppv_pkg::REG_INTRIN:   cfg_q.intrinsics <= pwdata;
        ppv_pkg::REG_IMG:      cfg_q.image_size <= pwdata[23:0];
        ppv_pkg::REG_FOV:      cfg_q.fov_margin <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      ppv_pkg::REG_ROT_X:    prdata = ppv_pkg::PDATA_W'(cfg_q.rot_x);
      ppv_pkg::REG_ROT_Y:    prdata = ppv_pkg::PDATA_W'(cfg_q.rot_y);
      ppv_pkg::REG_ROT_Z:    prdata = ppv_pkg::PDATA_W'(cfg_q.rot_z);
      ppv_pkg::REG_TRANS_XY: prdata = ppv_pkg::PDATA_W'(cfg_q.trans_xy);
      ppv_pkg::REG_TRANS_Z:  prdata = ppv_pkg::PDATA_W'(cfg_q.trans_z);
      ppv_pkg::REG_INTRIN:   prdata = cfg_q.intrinsics;
      ppv_pkg::REG_IMG:      prdata = ppv_pkg::PDATA_W'(cfg_q.image_size);
      ppv_pkg::REG_FOV:      prdata = ppv_pkg::PDATA_W'(cfg_q.fov_margin);
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> src/ppv_xform.sv
`default_nettype none
module ppv_xform (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           adv_i,
  input  wire logic           valid_i,
  input  ppv_pkg::pt_in_t     pt_i,
  input  ppv_pkg::cfg_t       cfg_i,
  output logic                valid_o,
  output ppv_pkg::proj_t      proj_o
);

  localparam int unsigned PRD_W = ppv_pkg::PRD_W;
  localparam int unsigned C28_W = ppv_pkg::C28_W;
  localparam int unsigned ROT_W = ppv_pkg::ROT_W;
  localparam int unsigned D_W   = ppv_pkg::D_W;
  localparam int unsigned P_W   = ppv_pkg::P_W;
  localparam int unsigned SH    = ppv_pkg::FRAC_SH;

  logic signed [ppv_pkg::PT_W-1:0]  pt [3];
  logic        [ppv_pkg::ROW_W-1:0] rows [3];
  logic signed [23:0]               trans [3];

  logic signed [PRD_W-1:0]          prod_q [3][3];
  logic [ppv_pkg::SCALE_W-1:0]      scale_a_q, scale_b_q;
  logic signed [C28_W-1:0]          c28_q [3];
  logic [2:0]                       valid_q;
  ppv_pkg::proj_t                   proj_q;

  logic signed [D_W-1:0]            xc, yc;
  logic signed [16:0]               fx, fy;

  assign pt[0]   = pt_i.pt_x;
  assign pt[1]   = pt_i.pt_y;
  assign pt[2]   = pt_i.pt_z;
  assign rows[0] = cfg_i.rot_x;
  assign rows[1] = cfg_i.rot_y;
  assign rows[2] = cfg_i.rot_z;
  assign trans[0] = cfg_i.trans_xy[23:0];
  assign trans[1] = cfg_i.trans_xy[47:24];
  assign trans[2] = cfg_i.trans_z;

  // rotation products
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= $signed(rows[r][c*ROT_W +: ROT_W]) * pt[c];
        end
      end
      scale_a_q <= pt_i.scale;
    end
  end

  // row sums plus translation, Q.28
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int r = 0; r < 3; r++) begin
        c28_q[r] <= C28_W'(prod_q[r][0]) + C28_W'(prod_q[r][1]) + C28_W'(prod_q[r][2])
                  + (C28_W'(trans[r]) <<< 16);
      end
      scale_b_q <= scale_a_q;
    end
  end

  // floor to Q.16 and numerator products
  assign xc = c28_q[0][C28_W-1:SH];
  assign yc = c28_q[1][C28_W-1:SH];
  assign fx = $signed({1'b0, cfg_i.intrinsics[15:0]});
  assign fy = $signed({1'b0, cfg_i.intrinsics[31:16]});

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      proj_q.num_u  <= P_W'(xc * fx);
      proj_q.num_v  <= P_W'(yc * fy);
      proj_q.den    <= c28_q[2][C28_W-1:SH];
      proj_q.scale  <= scale_b_q;
      proj_q.behind <= c28_q[2] < ppv_pkg::DEPTH_MIN_Q28;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  assign valid_o = valid_q[2];
  assign proj_o  = proj_q;

endmodule
`default_nettype wire

>>> src/ppv_div_step.sv
`default_nettype none
module ppv_div_step (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       adv_i,
  input  wire logic       valid_i,
  input  ppv_pkg::div_t   div_i,
  output logic            valid_o,
  output ppv_pkg::div_t   div_o
);

  localparam int unsigned D_W = ppv_pkg::D_W;
  localparam int unsigned Q_W = ppv_pkg::Q_W;

  ppv_pkg::div_t st_d, st_q;
  logic          valid_q;

  // one restoring step: shift in a numerator bit, subtract if it fits
  function automatic ppv_pkg::div_lane_t lane_step(ppv_pkg::div_lane_t l,
                                                   logic [D_W-1:0] den);
    logic [D_W:0]       r2;
    logic               fits;
    ppv_pkg::div_lane_t o;
    o      = l;
    r2     = {l.rem, l.num_lo[Q_W-1]};
    fits   = r2 >= {1'b0, den};
    o.num_lo = {l.num_lo[Q_W-2:0], 1'b0};
    o.rem  = fits ? D_W'(r2 - {1'b0, den}) : D_W'(r2);
    o.quo  = {l.quo[Q_W-2:0], fits};
    return o;
  endfunction

  always_comb begin
    st_d   = div_i;
    st_d.u = lane_step(div_i.u, div_i.den);
    st_d.v = lane_step(div_i.v, div_i.den);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = st_q;

endmodule
`default_nettype wire

>>> src/ppv_divider.sv
`default_nettype none
module ppv_divider (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       adv_i,
  input  wire logic       valid_i,
  input  ppv_pkg::proj_t  proj_i,
  output logic            valid_o,
  output ppv_pkg::div_t   div_o
);

  localparam int unsigned D_W   = ppv_pkg::D_W;
  localparam int unsigned P_W   = ppv_pkg::P_W;
  localparam int unsigned Q_W   = ppv_pkg::Q_W;
  localparam int unsigned HI_SH = ppv_pkg::HI_SH;
  localparam int unsigned SH    = ppv_pkg::FRAC_SH;

  ppv_pkg::div_t chain [Q_W+1];
  logic          vchain [Q_W+1];
  ppv_pkg::div_t pre_q;
  logic          pre_valid_q;

  // sign-magnitude split of the numerator (num << 12), top part seeds the remainder
  function automatic ppv_pkg::div_lane_t lane_init(logic signed [P_W-1:0] num,
                                                   logic [D_W-1:0] den);
    logic [P_W-1:0]     mag;
    logic [D_W-1:0]     top;
    ppv_pkg::div_lane_t l;
    mag      = num[P_W-1] ? P_W'(-num) : P_W'(num);
    top      = D_W'(mag[P_W-1:HI_SH]);
    l.rem    = top;
    l.num_lo = {mag[HI_SH-1:0], SH'(0)};
    l.quo    = '0;
    l.neg    = num[P_W-1];
    l.ovf    = top >= den;
    return l;
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pre_q.u      <= lane_init(proj_i.num_u, proj_i.den);
      pre_q.v      <= lane_init(proj_i.num_v, proj_i.den);
      pre_q.den    <= proj_i.den;
      pre_q.scale  <= proj_i.scale;
      pre_q.behind <= proj_i.behind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_valid_q <= 1'b0;
    end else if (adv_i) begin
      pre_valid_q <= valid_i;
    end
  end

  assign chain[0]  = pre_q;
  assign vchain[0] = pre_valid_q;

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    ppv_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv_i),
      .valid_i (vchain[k]),
      .div_i   (chain[k]),
      .valid_o (vchain[k+1]),
      .div_o   (chain[k+1])
    );
  end

  assign valid_o = vchain[Q_W];
  assign div_o   = chain[Q_W];

endmodule
`default_nettype wire

>>> src/ppv_finish.sv
`default_nettype none
module ppv_finish (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       adv_i,
  input  wire logic       valid_i,
  input  ppv_pkg::div_t   div_i,
  input  ppv_pkg::cfg_t   cfg_i,
  output logic            valid_o,
  output ppv_pkg::pt_out_t res_o
);

  localparam int unsigned Q_W   = ppv_pkg::Q_W;
  localparam int unsigned PIX_W = ppv_pkg::PIX_W;
  localparam int unsigned S_W   = ppv_pkg::SCALE_W;
  localparam int unsigned POS_W = ppv_pkg::POS_W;
  localparam int unsigned SUM_W = Q_W + 2;
  localparam int unsigned LO_W  = 24;
  localparam int unsigned PP_W  = LO_W + S_W;
  localparam int unsigned PROD_W = 64;

  localparam logic signed [SUM_W-1:0] CLAMP_HI = SUM_W'(1) <<< 45;
  localparam logic signed [SUM_W-1:0] CLAMP_LO = -CLAMP_HI;
  localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(32'sh7fffffff);
  localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(-64'sd2147483648);

  logic signed [PIX_W-1:0] pu_q, pv_q;
  logic [S_W-1:0]          scale_a_q;
  logic [1:0]              behind_q;
  logic                    vis_q;
  logic [PP_W-1:0]         ulo_q, vlo_q;
  logic signed [PP_W-1:0]  uhi_q, vhi_q;
  logic [2:0]              valid_q;
  ppv_pkg::pt_out_t        res_q;

  // signed quotient plus principal point, clamped
  function automatic logic signed [PIX_W-1:0] offset_clamp(ppv_pkg::div_lane_t l,
                                                            logic [15:0] cc);
    logic [Q_W-1:0]          q;
    logic signed [SUM_W-1:0] sq, p;
    q  = l.ovf ? '1 : l.quo;
    sq = l.neg ? -$signed(SUM_W'(q)) : $signed(SUM_W'(q));
    p  = sq + $signed(SUM_W'({cc, 12'd0}));
    if (p > CLAMP_HI) begin
      p = CLAMP_HI;
    end else if (p < CLAMP_LO) begin
      p = CLAMP_LO;
    end
    return PIX_W'(p);
  endfunction

  // margin window test on the unscaled pixel
  function automatic logic in_win(logic signed [PIX_W-1:0] p, logic [11:0] sz,
                                  logic [14:0] m);
    logic [28:0]        lo, hi;
    logic signed [47:0] pe, pc;
    lo = 29'(m * sz) + 29'(65536);
    hi = 29'((17'h10000 - {2'b00, m}) * sz);
    pe = 48'(p);
    pc = (pe + 48'sd65535) & ~48'h00000000ffff;
    return (pe >= $signed(48'(lo))) && (pc < $signed(48'(hi)));
  endfunction

  function automatic logic signed [POS_W-1:0] scale_sat(logic signed [PP_W-1:0] hi,
                                                        logic [PP_W-1:0] lo);
    logic signed [PROD_W-1:0] t, r;
    t = (PROD_W'(hi) <<< LO_W) + $signed(PROD_W'(lo));
    r = t >>> 12;
    if (r > SAT_HI) begin
      r = SAT_HI;
    end else if (r < SAT_LO) begin
      r = SAT_LO;
    end
    return POS_W'(r);
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pu_q        <= offset_clamp(div_i.u, cfg_i.intrinsics[47:32]);
      pv_q        <= offset_clamp(div_i.v, cfg_i.intrinsics[63:48]);
      scale_a_q   <= div_i.scale;
      behind_q[0] <= div_i.behind;

      vis_q       <= in_win(pu_q, cfg_i.image_size[11:0], cfg_i.fov_margin)
                  && in_win(pv_q, cfg_i.image_size[23:12], cfg_i.fov_margin);
      ulo_q       <= PP_W'(pu_q[LO_W-1:0] * scale_a_q);
      vlo_q       <= PP_W'(pv_q[LO_W-1:0] * scale_a_q);
      uhi_q       <= PP_W'($signed(pu_q[PIX_W-1:LO_W]) * $signed({1'b0, scale_a_q}));
      vhi_q       <= PP_W'($signed(pv_q[PIX_W-1:LO_W]) * $signed({1'b0, scale_a_q}));
      behind_q[1] <= behind_q[0];

      if (behind_q[1]) begin
        res_q.u_pos  <= '0;
        res_q.v_pos  <= '0;
        res_q.status <= ppv_pkg::ST_BEHIND;
      end else begin
        res_q.u_pos  <= scale_sat(uhi_q, ulo_q);
        res_q.v_pos  <= scale_sat(vhi_q, vlo_q);
        res_q.status <= vis_q ? ppv_pkg::ST_VISIBLE : ppv_pkg::ST_OUTSIDE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  assign valid_o = valid_q[2];
  assign res_o   = res_q;

endmodule
`default_nettype wire

>>> src/point_projection_visibility.sv
`default_nettype none
// Pinhole projection of a stream of world points, one point per clock while
// in_stall_o is low. Each point (Q12.12) is rotated and translated into the
// camera frame with the pose registers, tested against the 0.001 depth limit,
// projected through fx, fy, cx, cy, tested against the margin-shrunk image
// window and scaled to Q16.16 with saturation. The pipeline takes a new point
// every cycle while in_stall_o is low; a result beat passes through the
// transform stages, the pipelined divider (one quotient bit per stage, shared
// depth for u and v), the offset, window test and scaling stages, and the
// output register. A skid register behind the output lets the pipeline run
// while a finished beat waits; in_stall_o only rises once that skid register
// holds a beat, and then the whole pipeline holds. The register port is 64
// bits wide with register i at byte address 8*i, and registers should only
// be written while no beat is in flight.
module point_projection_visibility (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // point input
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  ppv_pkg::pt_in_t                   in_data_i,
  // result output
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output ppv_pkg::pt_out_t                  out_data_o,
  // register port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ppv_pkg::PAD_W-1:0]    paddr,
  input  wire logic [ppv_pkg::PDATA_W-1:0]  pwdata,
  output logic      [ppv_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready
);

  ppv_pkg::cfg_t    cfg;
  ppv_pkg::proj_t   proj;
  ppv_pkg::div_t    quot;
  ppv_pkg::pt_out_t fin;
  logic             proj_valid, quot_valid, fin_valid;
  logic             adv, take;

  ppv_pkg::pt_out_t out_q, skid_q;
  logic             out_valid_q, skid_valid_q;

  // the pipeline moves whenever the skid register is free
  assign adv        = !skid_valid_q;
  assign in_stall_o = skid_valid_q;
  assign take       = out_valid_q && !out_stall_i;

  ppv_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // rotate, translate, depth test, numerators
  ppv_xform u_xform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .pt_i    (in_data_i),
    .cfg_i   (cfg),
    .valid_o (proj_valid),
    .proj_o  (proj)
  );

  // x*f/z and y*f/z, truncating toward zero
  ppv_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (proj_valid),
    .proj_i  (proj),
    .valid_o (quot_valid),
    .div_o   (quot)
  );

  // principal point, window test, scaling and saturation
  ppv_finish u_fin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (quot_valid),
    .div_i   (quot),
    .cfg_i   (cfg),
    .valid_o (fin_valid),
    .res_o   (fin)
  );

  // output register with skid behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (fin_valid) begin
      if (!out_valid_q || take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (fin_valid) begin
      if (!out_valid_q || take) begin
        out_q <= fin;
      end else begin
        skid_q <= fin;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

>>> src/ppv_checker.sv
`default_nettype none
module ppv_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_stall_o,
  input  wire logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  input  ppv_pkg::pt_out_t                  out_data_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // input back-pressure only appears behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // a full skid stage implies a waiting result
  a_stall_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result shown");

  // points behind the camera carry zero coordinates
  a_behind_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ppv_pkg::ST_BEHIND)
      |-> (out_data_o.u_pos == '0) && (out_data_o.v_pos == '0))
    else $error("behind-camera result with nonzero position");

endmodule

bind point_projection_visibility ppv_checker u_ppv_checker (.*);
`default_nettype wire
